### src/sme_pkg.sv
package sme_pkg;

  // fixed field widths
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int MODE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 52;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam int SME_MAX_DIM = 8;

  // input commands
  localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

  // operation modes
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EMUL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PROD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRANS = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GRAM  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 3'd4;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // clamp a wide accumulator to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] upper;
    upper = v[ACC_W-1:DATA_W-1];
    if (&upper || ~|upper) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat32 = SAT_MIN;
    end else begin
      sat32 = SAT_MAX;
    end
  endfunction

endpackage

### src/sme_if.sv
interface sme_in_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;

  modport source(output valid, cmd, row_index, col_index, element_value, input ready);
  modport sink(input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;
  logic                     status;

  modport source(output valid, out_row, out_col, out_value, last, status, input ready);
  modport sink(input valid, out_row, out_col, out_value, last, status, output ready);
endinterface

### src/small_matrix_engine_top.sv
// channel   dir  transfer when      payload
// in_ch     in   valid && ready     cmd, row_index, col_index, element_value
// out_ch    out  valid && ready     out_row, out_col, out_value, last, status
// cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// element writes are accepted back to back while the engine is idle
// a run emits nr*nc results, each a read, multiply and accumulate step per term
// on the one shared multiply-accumulate for each of K terms, then a hand-off, K = a_cols for
// product, a_rows for gram, 1 otherwise; a dimension error goes to S_EMIT and raises out_ch
// valid from there when the output register is free
// rst_n is synchronous; the element stores are not cleared and are undefined until written
// an out_ch stall holds the output register while the next element is computed behind it
module small_matrix_engine_top import sme_pkg::*; #(
  parameter int MAX_DIM = SME_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sme_in_if.sink                in_ch,
  sme_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  // row-major entry address inside a store
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    mem_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    dim_ok = (d != '0) && (d <= DIM_W'(MAX_DIM));
  endfunction

  // configuration registers
  logic [MODE_W-1:0] op_mode_r;
  logic [DIM_W-1:0]  a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_ADD;
      a_rows_r  <= DIM_W'(1);
      a_cols_r  <= DIM_W'(1);
      b_rows_r  <= DIM_W'(1);
      b_cols_r  <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE: op_mode_r <= cfg_data[MODE_W-1:0];
        CFG_A_ROWS:  a_rows_r  <= cfg_data[DIM_W-1:0];
        CFG_A_COLS:  a_cols_r  <= cfg_data[DIM_W-1:0];
        CFG_B_ROWS:  b_rows_r  <= cfg_data[DIM_W-1:0];
        CFG_B_COLS:  b_cols_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state, counters and the output register
  state_t                   state_r;
  logic [IDX_W-1:0]         i_r, j_r, k_r;
  logic signed [ACC_W-1:0]  acc_r, term_r;
  logic signed [DATA_W-1:0] res_value_r;
  logic                     res_last_r, res_status_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r, out_status_r;

  // result shape, inner length and dimension check, straight from the registers
  logic             run_ok;
  logic [DIM_W-1:0] n_rows, n_cols, k_len;

  always_comb begin
    run_ok = 1'b0;
    n_rows = DIM_W'(1);
    n_cols = DIM_W'(1);
    k_len  = DIM_W'(1);
    case (op_mode_r)
      MODE_ADD, MODE_SUB, MODE_EMUL: begin
        run_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r) &&
                 (a_rows_r == b_rows_r) && (a_cols_r == b_cols_r);
        n_rows = a_rows_r;
        n_cols = a_cols_r;
      end
      MODE_PROD: begin
        run_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r) && dim_ok(b_cols_r) &&
                 (a_cols_r == b_rows_r);
        n_rows = a_rows_r;
        n_cols = b_cols_r;
        k_len  = a_cols_r;
      end
      MODE_TRANS: begin
        run_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r);
        n_rows = a_cols_r;
        n_cols = a_rows_r;
      end
      MODE_GRAM: begin
        run_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r);
        n_rows = a_cols_r;
        n_cols = a_cols_r;
        k_len  = a_rows_r;
      end
      default: ;
    endcase
  end

  // input transfer decode
  logic in_xfer, acc_run, wr_in_range, wr_a, wr_b;
  logic [ADDR_W-1:0] wr_addr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign acc_run     = in_xfer && (in_ch.cmd == CMD_RUN);
  assign wr_in_range = ({1'b0, in_ch.row_index} < DIM_W'(MAX_DIM)) &&
                       ({1'b0, in_ch.col_index} < DIM_W'(MAX_DIM));
  assign wr_a        = in_xfer && (in_ch.cmd == CMD_WR_A) && wr_in_range;
  assign wr_b        = in_xfer && (in_ch.cmd == CMD_WR_B) && wr_in_range;
  assign wr_addr     = mem_addr(in_ch.row_index, in_ch.col_index);

  // read addresses per mode: a0 is the left operand, a1 the second A column for gram
  logic [ADDR_W-1:0] a0_addr, a1_addr, b_addr;

  always_comb begin
    case (op_mode_r)
      MODE_TRANS: a0_addr = mem_addr(j_r, i_r);
      MODE_GRAM:  a0_addr = mem_addr(k_r, i_r);
      MODE_PROD:  a0_addr = mem_addr(i_r, k_r);
      default:    a0_addr = mem_addr(i_r, j_r);
    endcase
  end

  assign a1_addr = mem_addr(k_r, j_r);
  assign b_addr  = (op_mode_r == MODE_PROD) ? mem_addr(k_r, j_r) : mem_addr(i_r, j_r);

  // element stores: one write port, registered reads
  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];
  logic signed [DATA_W-1:0] rd_a0_r, rd_a1_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_ch.element_value;
    end
    rd_a0_r <= mem_a[a0_addr];
    rd_a1_r <= mem_a[a1_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_ch.element_value;
    end
    rd_b_r <= mem_b[b_addr];
  end

  // shared arithmetic: one 32x32 multiplier, or an add/subtract, per term
  logic signed [DATA_W-1:0]   mul_rhs;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    acc_sum;

  assign mul_rhs = (op_mode_r == MODE_GRAM) ? rd_a1_r : rd_b_r;
  assign prod    = rd_a0_r * mul_rhs;
  // arithmetic shift drops the fraction bits, rounding toward minus infinity
  assign prod_sh = prod >>> FRAC_W;

  always_comb begin
    case (op_mode_r)
      MODE_ADD:   term = ACC_W'(rd_a0_r) + ACC_W'(rd_b_r);
      MODE_SUB:   term = ACC_W'(rd_a0_r) - ACC_W'(rd_b_r);
      MODE_TRANS: term = ACC_W'(rd_a0_r);
      default:    term = prod_sh[ACC_W-1:0];
    endcase
  end

  assign acc_sum = acc_r + term_r;

  logic k_done, row_done, col_done;

  assign k_done   = ({1'b0, k_r} + DIM_W'(1)) == k_len;
  assign row_done = ({1'b0, i_r} + DIM_W'(1)) == n_rows;
  assign col_done = ({1'b0, j_r} + DIM_W'(1)) == n_cols;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      // in S_EMIT a drained output register is refilled by the hand-off below
      if (out_ch.valid && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc_run) begin
            i_r   <= '0;
            j_r   <= '0;
            k_r   <= '0;
            acc_r <= '0;
            if (run_ok) begin
              state_r <= S_READ;
            end else begin
              // single error result at row 0, col 0
              res_value_r  <= '0;
              res_last_r   <= 1'b1;
              res_status_r <= 1'b1;
              state_r      <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          term_r  <= term;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (k_done) begin
            res_value_r  <= sat32(acc_sum);
            res_last_r   <= row_done && col_done;
            res_status_r <= 1'b0;
            state_r      <= S_EMIT;
          end else begin
            acc_r   <= acc_sum;
            k_r     <= k_r + IDX_W'(1);
            state_r <= S_READ;
          end
        end
        S_EMIT: begin
          // hand off once the output register is free or being drained
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_row_r    <= i_r;
            out_col_r    <= j_r;
            out_value_r  <= res_value_r;
            out_last_r   <= res_last_r;
            out_status_r <= res_status_r;
            acc_r        <= '0;
            k_r          <= '0;
            if (res_last_r) begin
              state_r <= S_IDLE;
            end else begin
              if (col_done) begin
                j_r <= '0;
                i_r <= i_r + IDX_W'(1);
              end else begin
                j_r <= j_r + IDX_W'(1);
              end
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_status_r;

  // a failed dimension check goes straight to the hand-off with the error flag
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_run && !run_ok) |=> (state_r == S_EMIT && res_status_r && res_last_r))
    else $error("dimension error did not produce an error result");

  // the inner index never runs past the inner length
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> ({1'b0, k_r} < k_len))
    else $error("inner index beyond inner length");

  // an error result always closes its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> out_ch.last)
    else $error("error result without last");

  // nothing is taken in while a run is still in the sequencer
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_MUL || state_r == S_ACC) |-> !in_xfer)
    else $error("input transfer during a run");

endmodule
